// File: design/lcfg_pkg.sv
// Package for the LED comet frame generator.
// Holds the field widths, register indexes, state codes and the structs shared by the modules.
// No dependencies.
`timescale 1ns / 1ps

package lcfg_pkg;

    // Strip limits and field widths.
    localparam int MAX_LEDS  = 64;
    localparam int COLOR_W   = 8;
    localparam int CHAN_W    = 7;
    localparam int INDEX_W   = 6;
    localparam int POS_W     = 7;
    localparam int SIZE_W    = 7;
    localparam int PROD_W    = COLOR_W + SIZE_W;
    localparam int DIV_W     = SIZE_W + 1;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 7;

    // Bit-serial schedule of one channel lane.
    localparam int MUL_STEPS = SIZE_W;
    localparam int DIV_STEPS = CHAN_W;
    localparam int STEP_W    = 4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_LED_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COMET_SIZE = 2'd1;

    // Register reset values.
    localparam logic [CFG_W-1:0] LED_COUNT_RST  = 7'd16;
    localparam logic [CFG_W-1:0] COMET_SIZE_RST = 7'd4;

    // Frame sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_LOAD = 4'b0010,
        ST_CALC = 4'b0100,
        ST_PUSH = 4'b1000
    } state_t;

    // One pixel job handed to the channel lanes.
    typedef struct packed {
        logic              start;
        logic [SIZE_W-1:0] mult;
        logic [SIZE_W-1:0] size;
    } job_t;

    // Hand-off of a finished pixel to the output register.
    typedef struct packed {
        logic               push;
        logic [INDEX_W-1:0] index;
        logic               last;
    } push_t;

endpackage

// File: design/led_comet_frame_generator.sv
// LED comet frame generator: each input transfer is one frame tick with an RGBW head color,
// and the block answers with one output transfer per pixel of the strip, pixel 0 first,
// tlast on the final pixel. Each pixel goes through one load, then seven bit-serial
// multiply steps and seven restoring divide steps in the four channel lanes that run side
// by side, then one hand-off; the input is ready again once the last pixel sits in the
// output register. There is no clearing pass after reset. Depends on lcfg_pkg, lcfg_lane
// and lcfg_ctrl.
`timescale 1ns / 1ps

module led_comet_frame_generator
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [lcfg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lcfg_pkg::CFG_W-1:0]      cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // base_red[7:0], base_green[15:8], base_blue[23:16], base_white[31:24]
    input  logic [31:0]                     s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // pixel_index[5:0], out_red[12:6], out_green[19:13], out_blue[26:20],
    // out_white[33:27], zero fill[39:34]
    output logic [39:0]                     m_tdata,
    output logic                            m_tlast
);

    localparam int OUT_W = lcfg_pkg::INDEX_W + 4 * lcfg_pkg::CHAN_W;

    lcfg_pkg::job_t                 job;
    lcfg_pkg::push_t                push;
    logic [31:0]                    color_reg;
    logic [lcfg_pkg::CHAN_W-1:0]    q_red, q_green, q_blue, q_white;
    logic                           done_red, done_green, done_blue, done_white;
    logic                           lane_done;
    logic                           out_free;
    logic                           out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]               out_data_reg;
    logic                           out_last_reg;

    lcfg_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .job       (job),
        .lane_done (lane_done),
        .out_free  (out_free),
        .push      (push)
    );

    lcfg_lane u_lane_red
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .job      (job),
        .color    (color_reg[7:0]),
        .quotient (q_red),
        .done     (done_red)
    );

    lcfg_lane u_lane_green
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .job      (job),
        .color    (color_reg[15:8]),
        .quotient (q_green),
        .done     (done_green)
    );

    lcfg_lane u_lane_blue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .job      (job),
        .color    (color_reg[23:16]),
        .quotient (q_blue),
        .done     (done_blue)
    );

    lcfg_lane u_lane_white
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .job      (job),
        .color    (color_reg[31:24]),
        .quotient (q_white),
        .done     (done_white)
    );

    assign lane_done = done_red & done_green & done_blue & done_white;

    // Hold the head color of the accepted tick for the whole frame.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            color_reg <= s_tdata;
        end
    end

    // Output register: free when empty or when its transfer completes this cycle.
    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        if (push.push)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.push)
        begin
            out_data_reg <= {q_white, q_blue, q_green, q_red, push.index};
            out_last_reg <= push.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(40 - OUT_W){1'b0}}, out_data_reg};
    assign m_tlast  = out_last_reg;

endmodule

// File: design/lcfg_lane.sv
// One color channel lane: bit-serial shift-add multiply, then restoring divide.
// Computes floor(color * mult / (2 * size)). Depends on lcfg_pkg.
`timescale 1ns / 1ps

module lcfg_lane
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  lcfg_pkg::job_t                job,
    input  logic [lcfg_pkg::COLOR_W-1:0]  color,
    output logic [lcfg_pkg::CHAN_W-1:0]   quotient,
    output logic                          done
);

    localparam logic [lcfg_pkg::STEP_W-1:0] MUL_LAST =
        lcfg_pkg::STEP_W'(lcfg_pkg::MUL_STEPS - 1);
    localparam logic [lcfg_pkg::STEP_W-1:0] STEP_LAST =
        lcfg_pkg::STEP_W'(lcfg_pkg::MUL_STEPS + lcfg_pkg::DIV_STEPS - 1);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [lcfg_pkg::STEP_W-1:0]   step_reg, step_next;
    logic [lcfg_pkg::PROD_W-1:0]   mcand_reg, mcand_next;
    logic [lcfg_pkg::SIZE_W-1:0]   mplier_reg, mplier_next;
    logic [lcfg_pkg::PROD_W-1:0]   acc_reg, acc_next;
    logic [lcfg_pkg::DIV_W-1:0]    rem_reg, rem_next;
    logic [lcfg_pkg::CHAN_W-1:0]   low_reg, low_next;
    logic [lcfg_pkg::CHAN_W-1:0]   quo_reg, quo_next;
    logic [lcfg_pkg::DIV_W-1:0]    div_reg, div_next;

    logic [lcfg_pkg::PROD_W-1:0]   acc_sum;
    logic [lcfg_pkg::DIV_W:0]      trial;
    logic [lcfg_pkg::DIV_W:0]      diff;
    logic                          fits;

    // One multiply step adds the shifted color; one divide step tries a subtract.
    always_comb
    begin
        acc_sum = acc_reg + (mplier_reg[0] ? mcand_reg : '0);
        trial   = {rem_reg, low_reg[lcfg_pkg::CHAN_W-1]};
        diff    = trial - {1'b0, div_reg};
        fits    = (trial >= {1'b0, div_reg});

        busy_next   = busy_reg;
        done_next   = 1'b0;
        step_next   = step_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        acc_next    = acc_reg;
        rem_next    = rem_reg;
        low_next    = low_reg;
        quo_next    = quo_reg;
        div_next    = div_reg;

        if (job.start)
        begin
            busy_next   = 1'b1;
            step_next   = '0;
            mcand_next  = {{lcfg_pkg::SIZE_W{1'b0}}, color};
            mplier_next = job.mult;
            acc_next    = '0;
            div_next    = {job.size, 1'b0};
            quo_next    = '0;
        end
        else if (busy_reg)
        begin
            step_next = step_reg + 1'b1;
            if (step_reg <= MUL_LAST)
            begin
                acc_next    = acc_sum;
                mcand_next  = {mcand_reg[lcfg_pkg::PROD_W-2:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[lcfg_pkg::SIZE_W-1:1]};
                // The product is below 128 times the divisor, so its upper bits
                // already form a valid partial remainder.
                if (step_reg == MUL_LAST)
                begin
                    rem_next = acc_sum[lcfg_pkg::PROD_W-1:lcfg_pkg::CHAN_W];
                    low_next = acc_sum[lcfg_pkg::CHAN_W-1:0];
                end
            end
            else
            begin
                quo_next = {quo_reg[lcfg_pkg::CHAN_W-2:0], fits};
                rem_next = fits ? diff[lcfg_pkg::DIV_W-1:0] : trial[lcfg_pkg::DIV_W-1:0];
                low_next = {low_reg[lcfg_pkg::CHAN_W-2:0], 1'b0};
            end
            if (step_reg == STEP_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // Datapath shift registers.
    always_ff @(posedge clk)
    begin
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        acc_reg    <= acc_next;
        rem_reg    <= rem_next;
        low_reg    <= low_next;
        quo_reg    <= quo_next;
        div_reg    <= div_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

`ifndef NO_ASSERTIONS
    // A job is never started while the previous one is still being worked on.
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        job.start |-> !busy_reg)
        else $error("lane started while busy");

    // A job finishes after the fixed multiply and divide schedule.
    a_done_time: assert property (@(posedge clk) disable iff (!rst_n)
        job.start |-> ##15 done)
        else $error("lane result not ready on schedule");
`endif

endmodule

// File: design/lcfg_ctrl.sv
// Frame sequencer: configuration registers, head position and the per-pixel loop.
// Works out the tail distance and issues one job per pixel. Depends on lcfg_pkg.
`timescale 1ns / 1ps

module lcfg_ctrl
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [lcfg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lcfg_pkg::CFG_W-1:0]      cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    output lcfg_pkg::job_t                  job,
    input  logic                            lane_done,
    input  logic                            out_free,
    output lcfg_pkg::push_t                 push
);

    lcfg_pkg::state_t               state_reg, state_next;
    logic [lcfg_pkg::CFG_W-1:0]     led_count_reg;
    logic [lcfg_pkg::CFG_W-1:0]     comet_size_reg;
    logic [lcfg_pkg::POS_W-1:0]     head_reg, head_next;
    logic [lcfg_pkg::INDEX_W-1:0]   pix_reg, pix_next;

    logic [lcfg_pkg::POS_W-1:0]     n_eff;
    logic [lcfg_pkg::SIZE_W-1:0]    s_eff;
    logic [lcfg_pkg::POS_W:0]       wrap_dist;
    logic [lcfg_pkg::POS_W-1:0]     tail_dist;
    logic [lcfg_pkg::SIZE_W-1:0]    mult;
    logic                           is_last;
    logic                           do_push;

    // Clamp the pixel count to the strip, and treat a zero pixel count or a zero tail as one pixel.
    always_comb
    begin
        if (led_count_reg == '0)
        begin
            n_eff = 7'd1;
        end
        else if (led_count_reg > lcfg_pkg::POS_W'(lcfg_pkg::MAX_LEDS))
        begin
            n_eff = lcfg_pkg::POS_W'(lcfg_pkg::MAX_LEDS);
        end
        else
        begin
            n_eff = led_count_reg;
        end
        s_eff = (comet_size_reg == '0) ? 7'd1 : comet_size_reg;
    end

    // Circular distance behind the head and the fade weight it gives.
    always_comb
    begin
        wrap_dist = {1'b0, n_eff} + {1'b0, head_reg} - {2'b00, pix_reg};
        if ({1'b0, pix_reg} <= head_reg)
        begin
            tail_dist = head_reg - {1'b0, pix_reg};
        end
        else
        begin
            tail_dist = wrap_dist[lcfg_pkg::POS_W-1:0];
        end
        mult    = (tail_dist <= s_eff) ? (s_eff - tail_dist) : '0;
        is_last = ({1'b0, pix_reg} == (n_eff - 7'd1));
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        pix_next   = pix_reg;
        do_push    = 1'b0;

        case (state_reg)
            lcfg_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (head_reg == '0 || head_reg >= n_eff)
                    begin
                        head_next = 7'd1;
                    end
                    else
                    begin
                        head_next = head_reg + 7'd1;
                    end
                    pix_next   = '0;
                    state_next = lcfg_pkg::ST_LOAD;
                end
            end
            lcfg_pkg::ST_LOAD:
            begin
                state_next = lcfg_pkg::ST_CALC;
            end
            lcfg_pkg::ST_CALC,
            lcfg_pkg::ST_PUSH:
            begin
                if (state_reg == lcfg_pkg::ST_PUSH || lane_done)
                begin
                    if (out_free)
                    begin
                        do_push = 1'b1;
                        if (is_last)
                        begin
                            state_next = lcfg_pkg::ST_IDLE;
                        end
                        else
                        begin
                            pix_next   = pix_reg + 6'd1;
                            state_next = lcfg_pkg::ST_LOAD;
                        end
                    end
                    else
                    begin
                        state_next = lcfg_pkg::ST_PUSH;
                    end
                end
            end
            default:
            begin
                state_next = lcfg_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer state, head and pixel counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lcfg_pkg::ST_IDLE;
            head_reg  <= '0;
            pix_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            pix_reg   <= pix_next;
        end
    end

    // Configuration writes; unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            led_count_reg  <= lcfg_pkg::LED_COUNT_RST;
            comet_size_reg <= lcfg_pkg::COMET_SIZE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lcfg_pkg::REG_LED_COUNT:  led_count_reg  <= cfg_data;
                lcfg_pkg::REG_COMET_SIZE: comet_size_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign s_tready   = (state_reg == lcfg_pkg::ST_IDLE);
    assign job.start  = (state_reg == lcfg_pkg::ST_LOAD);
    assign job.mult   = mult;
    assign job.size   = s_eff;
    assign push.push  = do_push;
    assign push.index = pix_reg;
    assign push.last  = is_last;

`ifndef NO_ASSERTIONS
    // A pixel is only handed over when the output register can take it.
    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        push.push |-> out_free)
        else $error("pixel pushed into a full output register");

    // Handing over the last pixel of a frame frees the input for the next tick.
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (push.push && push.last) |=> s_tready)
        else $error("input not ready after the last pixel");
`endif

endmodule
